/* hdl/assert_macros.svh */
// Assertion macros used by the warp pixel fetch top level.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/bwpf_pkg.sv */
// Package of the bilinear warp pixel fetch: image geometry, field widths,
// payload structs, coefficient reset values and the memory request type.
// Depends on nothing.
package bwpf_pkg;

  localparam int IMAGE_ROWS = 512;
  localparam int IMAGE_COLS = 512;
  localparam int ROW_W      = $clog2(IMAGE_ROWS);
  localparam int COL_W      = $clog2(IMAGE_COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;

  localparam int COORD_W   = 9;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int COEF_W    = 48;
  localparam int FRAC_W    = 32;
  localparam int SPLIT_W   = 24;
  localparam int HI_W      = COEF_W - SPLIT_W;
  localparam int FLOOR_SH  = FRAC_W - SPLIT_W;
  localparam int RC_W      = 2 * COORD_W;
  localparam int NUM_TERMS = 4;
  localparam int NUM_REGS  = 2 * NUM_TERMS;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // Product and sum widths of the mapping pipeline.
  localparam int HPROD_W = HI_W + RC_W + 1;
  localparam int LPROD_W = SPLIT_W + RC_W;
  localparam int HSUM_W  = HPROD_W + 2;
  localparam int LSUM_W  = LPROD_W + 2;
  localparam int POS_W   = HSUM_W + 1;
  localparam int INT_W   = POS_W - 1 - FLOOR_SH;

  localparam int REG_X_FROM_ROW     = 0;
  localparam int REG_X_FROM_COL     = 1;
  localparam int REG_X_FROM_PRODUCT = 2;
  localparam int REG_X_OFFSET       = 3;
  localparam int REG_Y_FROM_ROW     = 4;
  localparam int REG_Y_FROM_COL     = 5;
  localparam int REG_Y_FROM_PRODUCT = 6;
  localparam int REG_Y_OFFSET       = 7;

  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(64'h1_0000_0000);
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;

  // Entry i holds the reset value of register i.
  localparam logic [NUM_REGS-1:0][COEF_W-1:0] COEF_RESET = {
    COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
    COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE
  };

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef logic [NUM_TERMS-1:0][COEF_W-1:0] coef_set_t;

  typedef struct packed {
    opcode_e              opcode;
    logic [COORD_W-1:0]   pixel_row;
    logic [COORD_W-1:0]   pixel_col;
    logic [CHAN_W-1:0]    in_red;
    logic [CHAN_W-1:0]    in_green;
    logic [CHAN_W-1:0]    in_blue;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } mem_req_t;

endpackage

/* hdl/bilinear_warp_pixel_fetch.sv */
// Top level of the bilinear warp pixel fetch: coefficient registers, input
// stage, two coordinate mapping pipelines, clamping and the image memory.
// Depends on bwpf_pkg, bwpf_map, bwpf_mem and assert_macros.svh.
//
// The block takes one transfer per clock and never raises busy. A write
// stores a pixel and gives no result; a write outside the image is dropped.
// A query gives exactly one result, driven on result_o with result_valid_o
// high for one cycle, once the item has passed the input, mapping, memory
// request and read registers; the receiver cannot hold it off, so it must
// take every result. The rate is set by the fully pipelined mapping
// multipliers and the single memory port, which serves one write or one
// read per cycle in item order. The image memory needs no clearing after
// reset. Coefficients should be written only while no transfer is in flight.
`include "assert_macros.svh"

module bilinear_warp_pixel_fetch (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  bwpf_pkg::item_t                  item_i,
  input  logic                             cfg_we_i,
  input  logic [bwpf_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bwpf_pkg::COEF_W-1:0]      cfg_data_i,
  output logic                             result_valid_o,
  output bwpf_pkg::result_t                result_o
);

  localparam int NUM_TERMS = bwpf_pkg::NUM_TERMS;
  localparam int ROW_W     = bwpf_pkg::ROW_W;
  localparam int COL_W     = bwpf_pkg::COL_W;
  localparam int ADDR_W    = bwpf_pkg::ADDR_W;
  localparam int POS_W     = bwpf_pkg::POS_W;
  localparam int INT_W     = bwpf_pkg::INT_W;
  localparam int FLOOR_SH  = bwpf_pkg::FLOOR_SH;
  localparam int MAP_DEPTH = 3;

  logic [bwpf_pkg::COEF_W-1:0]       coef_q [bwpf_pkg::NUM_REGS];
  bwpf_pkg::coef_set_t               x_coef, y_coef;
  logic                              accept;
  logic                              s1_valid_q;
  bwpf_pkg::item_t                   s1_item_q;
  logic [bwpf_pkg::RC_W-1:0]         s1_rc_q;
  logic [MAP_DEPTH-1:0]              dly_valid_q;
  bwpf_pkg::item_t                   dly_item_q [MAP_DEPTH];
  logic signed [POS_W-1:0]           x_pos, y_pos;
  logic [INT_W-1:0]                  x_int, y_int;
  logic [ROW_W-1:0]                  src_row;
  logic [COL_W-1:0]                  src_col;
  bwpf_pkg::item_t                   cur_item;
  logic                              wr_in_range;
  bwpf_pkg::mem_req_t                mem_req_d, mem_req_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bwpf_pkg::NUM_REGS; i++) begin
        coef_q[i] <= bwpf_pkg::COEF_RESET[i];
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      x_coef[k] = coef_q[k];
      y_coef[k] = coef_q[NUM_TERMS + k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      dly_valid_q <= '0;
    end else begin
      s1_valid_q  <= accept;
      dly_valid_q <= {dly_valid_q[MAP_DEPTH-2:0], s1_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q     <= item_i;
    s1_rc_q       <= item_i.pixel_row * item_i.pixel_col;
    dly_item_q[0] <= s1_item_q;
    for (int i = 1; i < MAP_DEPTH; i++) begin
      dly_item_q[i] <= dly_item_q[i-1];
    end
  end

  bwpf_map u_map_row (
    .clk_i  (clk_i),
    .coef_i (x_coef),
    .row_i  (s1_item_q.pixel_row),
    .col_i  (s1_item_q.pixel_col),
    .rc_i   (s1_rc_q),
    .pos_o  (x_pos)
  );

  bwpf_map u_map_col (
    .clk_i  (clk_i),
    .coef_i (y_coef),
    .row_i  (s1_item_q.pixel_row),
    .col_i  (s1_item_q.pixel_col),
    .rc_i   (s1_rc_q),
    .pos_o  (y_pos)
  );

  // Floor, then clamp each coordinate into the image.
  assign x_int = x_pos[POS_W-2:FLOOR_SH];
  assign y_int = y_pos[POS_W-2:FLOOR_SH];

  always_comb begin
    if (x_pos < 0) begin
      src_row = '0;
    end else if (x_int >= INT_W'(bwpf_pkg::IMAGE_ROWS)) begin
      src_row = ROW_W'(bwpf_pkg::IMAGE_ROWS - 1);
    end else begin
      src_row = x_int[ROW_W-1:0];
    end
    if (y_pos < 0) begin
      src_col = '0;
    end else if (y_int >= INT_W'(bwpf_pkg::IMAGE_COLS)) begin
      src_col = COL_W'(bwpf_pkg::IMAGE_COLS - 1);
    end else begin
      src_col = y_int[COL_W-1:0];
    end
  end

  assign cur_item    = dly_item_q[MAP_DEPTH-1];
  assign wr_in_range = (32'(cur_item.pixel_row) < bwpf_pkg::IMAGE_ROWS) &&
                       (32'(cur_item.pixel_col) < bwpf_pkg::IMAGE_COLS);

  always_comb begin
    mem_req_d.we    = (cur_item.opcode == bwpf_pkg::OP_WRITE);
    mem_req_d.valid = dly_valid_q[MAP_DEPTH-1] &&
                      ((cur_item.opcode == bwpf_pkg::OP_QUERY) || wr_in_range);
    mem_req_d.wdata = {cur_item.in_red, cur_item.in_green, cur_item.in_blue};
    if (cur_item.opcode == bwpf_pkg::OP_QUERY) begin
      mem_req_d.addr = {src_row, src_col};
    end else begin
      mem_req_d.addr = {ROW_W'(cur_item.pixel_row), COL_W'(cur_item.pixel_col)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_req_q <= '0;
    end else begin
      mem_req_q <= mem_req_d;
    end
  end

  bwpf_mem u_mem (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (mem_req_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `ASSERT_IMPLY(a_result_from_query, clk_i, rst_ni, result_valid_o, $past(accept && (item_i.opcode == bwpf_pkg::OP_QUERY), 6))
  `ASSERT_IMPLY(a_mem_addr_in_image, clk_i, rst_ni, mem_req_q.valid, (32'(mem_req_q.addr[ADDR_W-1:COL_W]) < bwpf_pkg::IMAGE_ROWS) && (32'(mem_req_q.addr[COL_W-1:0]) < bwpf_pkg::IMAGE_COLS))
  `ASSERT_NEXT(a_write_no_result, clk_i, rst_ni, mem_req_q.valid && mem_req_q.we, !result_valid_o)

endmodule

/* hdl/bwpf_map.sv */
// Three-stage mapping pipeline for one source coordinate: split-coefficient
// products, partial sums, then the combined fixed-point position.
// Depends on bwpf_pkg.
module bwpf_map (
  input  logic                                  clk_i,
  input  bwpf_pkg::coef_set_t                   coef_i,
  input  logic [bwpf_pkg::COORD_W-1:0]          row_i,
  input  logic [bwpf_pkg::COORD_W-1:0]          col_i,
  input  logic [bwpf_pkg::RC_W-1:0]             rc_i,
  output logic signed [bwpf_pkg::POS_W-1:0]     pos_o
);

  localparam int NPROD   = bwpf_pkg::NUM_TERMS - 1;
  localparam int HI_W    = bwpf_pkg::HI_W;
  localparam int SPLIT_W = bwpf_pkg::SPLIT_W;
  localparam int RC_W    = bwpf_pkg::RC_W;
  localparam int HPROD_W = bwpf_pkg::HPROD_W;
  localparam int LPROD_W = bwpf_pkg::LPROD_W;
  localparam int HSUM_W  = bwpf_pkg::HSUM_W;
  localparam int LSUM_W  = bwpf_pkg::LSUM_W;
  localparam int POS_W   = bwpf_pkg::POS_W;
  localparam int COEF_W  = bwpf_pkg::COEF_W;

  logic [RC_W-1:0]              mult     [NPROD];
  logic signed [HPROD_W-1:0]    hprod_d  [NPROD];
  logic [LPROD_W-1:0]           lprod_d  [NPROD];
  logic signed [HPROD_W-1:0]    hprod_q  [NPROD];
  logic [LPROD_W-1:0]           lprod_q  [NPROD];
  logic signed [HI_W-1:0]       hoff_q;
  logic [SPLIT_W-1:0]           loff_q;
  logic signed [HSUM_W-1:0]     hsum_d, hsum_q;
  logic [LSUM_W-1:0]            lsum_d, lsum_q;
  logic signed [POS_W-1:0]      pos_d, pos_q;

  always_comb begin
    mult[0] = RC_W'(row_i);
    mult[1] = RC_W'(col_i);
    mult[2] = rc_i;
    for (int k = 0; k < NPROD; k++) begin
      hprod_d[k] = $signed(coef_i[k][COEF_W-1:SPLIT_W]) * $signed({1'b0, mult[k]});
      lprod_d[k] = coef_i[k][SPLIT_W-1:0] * mult[k];
    end
  end

  always_ff @(posedge clk_i) begin
    hprod_q <= hprod_d;
    lprod_q <= lprod_d;
    hoff_q  <= $signed(coef_i[NPROD][COEF_W-1:SPLIT_W]);
    loff_q  <= coef_i[NPROD][SPLIT_W-1:0];
  end

  always_comb begin
    hsum_d = HSUM_W'(hoff_q);
    lsum_d = LSUM_W'(loff_q);
    for (int k = 0; k < NPROD; k++) begin
      hsum_d = hsum_d + HSUM_W'(hprod_q[k]);
      lsum_d = lsum_d + LSUM_W'(lprod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    hsum_q <= hsum_d;
    lsum_q <= lsum_d;
  end

  // The low sum carries into the high sum at the split point.
  assign pos_d = POS_W'(hsum_q) + POS_W'($signed({1'b0, lsum_q[LSUM_W-1:SPLIT_W]}));

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign pos_o = pos_q;

endmodule

/* hdl/bwpf_mem.sv */
// Source image memory: one synchronous port that takes a pixel write or a
// registered pixel read each cycle, and the result strobe of reads.
// Depends on bwpf_pkg.
module bwpf_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bwpf_pkg::mem_req_t req_i,
  output logic               result_valid_o,
  output bwpf_pkg::result_t  result_o
);

  logic [bwpf_pkg::PIX_W-1:0] pix_mem_q [bwpf_pkg::MEM_DEPTH];
  logic [bwpf_pkg::PIX_W-1:0] rdata_q;
  logic                       result_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      if (req_i.we) begin
        pix_mem_q[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= pix_mem_q[req_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= req_i.valid && !req_i.we;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = bwpf_pkg::result_t'(rdata_q);

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of bilinear_warp_pixel_fetch: pixel writes and warped queries
// under several coefficient sets, checked against an inline prediction of the fetch.
// Depends on bwpf_pkg and the block's RTL.
module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 190;
  localparam int DRAIN_CYCLES = 12;

  localparam int IMAGE_ROWS = bwpf_pkg::IMAGE_ROWS;
  localparam int IMAGE_COLS = bwpf_pkg::IMAGE_COLS;
  localparam int COORD_W    = bwpf_pkg::COORD_W;
  localparam int COL_W      = bwpf_pkg::COL_W;
  localparam int ADDR_W     = bwpf_pkg::ADDR_W;
  localparam int PIX_W      = bwpf_pkg::PIX_W;
  localparam int COEF_W     = bwpf_pkg::COEF_W;
  localparam int FRAC_W     = bwpf_pkg::FRAC_W;
  localparam int NUM_TERMS  = bwpf_pkg::NUM_TERMS;
  localparam int NUM_REGS   = bwpf_pkg::NUM_REGS;
  localparam int REG_IDX_W  = bwpf_pkg::REG_IDX_W;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  bwpf_pkg::item_t      item_i     = '0;
  logic                 cfg_we_i   = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [COEF_W-1:0]    cfg_data_i = '0;
  logic                 result_valid_o;
  bwpf_pkg::result_t    result_o;

  bwpf_pkg::item_t   pending_items[$];
  bwpf_pkg::result_t pixels_due[$];
  bwpf_pkg::result_t image_copy[logic [ADDR_W-1:0]];
  bit                written_pos[logic [ADDR_W-1:0]];

  logic [NUM_REGS-1:0][COEF_W-1:0] reg_copy;
  bwpf_pkg::coef_set_t gen_x, gen_y;
  int sender_idle_pct = 35;
  int queued;
  int error_count = 0;
  int cycle_count = 0;

  bilinear_warp_pixel_fetch DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [COORD_W-1:0] src_coord(input bwpf_pkg::coef_set_t k,
                                                   input logic [COORD_W-1:0] row,
                                                   input logic [COORD_W-1:0] col,
                                                   input int limit);
    logic signed [79:0] k0, k1, k2, k3, rv, cv, pv, acc, whole;
    k0 = $signed(k[0]);
    k1 = $signed(k[1]);
    k2 = $signed(k[2]);
    k3 = $signed(k[3]);
    rv = row;
    cv = col;
    pv = rv * cv;
    acc = k0 * rv + k1 * cv + k2 * pv + k3;
    if (acc < 0) return '0;
    whole = acc >>> FRAC_W;
    if (whole >= limit) return COORD_W'(limit - 1);
    return whole[COORD_W-1:0];
  endfunction

  task automatic predict_fetch(input bwpf_pkg::item_t it);
    logic [ADDR_W-1:0] key;
    bwpf_pkg::result_t px;
    if (it.opcode == bwpf_pkg::OP_WRITE) begin
      px.out_red   = it.in_red;
      px.out_green = it.in_green;
      px.out_blue  = it.in_blue;
      image_copy[{it.pixel_row, it.pixel_col}] = px;
    end else begin
      key = {src_coord(reg_copy[NUM_TERMS-1:0], it.pixel_row, it.pixel_col, IMAGE_ROWS),
             src_coord(reg_copy[NUM_REGS-1:NUM_TERMS], it.pixel_row, it.pixel_col,
                       IMAGE_COLS)};
      px = image_copy.exists(key) ? image_copy[key] : '0;
      pixels_due.push_back(px);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      item_i   <= '0;
      reg_copy <= bwpf_pkg::COEF_RESET;
    end else begin
      if (cfg_we_i) reg_copy[cfg_idx_i] <= cfg_data_i;
      if (start && !busy) predict_fetch(item_i);
      if (!start || !busy) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          item_i <= pending_items.pop_front();
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    bwpf_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_o);
        error_count++;
      end else begin
        want = pixels_due.pop_front();
        if (result_o.out_red !== want.out_red) begin
          $display("%0t: red mismatch: expected %h, actual %h", $time, want.out_red,
                   result_o.out_red);
          error_count++;
        end
        if (result_o.out_green !== want.out_green) begin
          $display("%0t: green mismatch: expected %h, actual %h", $time, want.out_green,
                   result_o.out_green);
          error_count++;
        end
        if (result_o.out_blue !== want.out_blue) begin
          $display("%0t: blue mismatch: expected %h, actual %h", $time, want.out_blue,
                   result_o.out_blue);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_write(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                            input logic [PIX_W-1:0] rgb);
    bwpf_pkg::item_t it;
    it.opcode    = bwpf_pkg::OP_WRITE;
    it.pixel_row = row;
    it.pixel_col = col;
    it.in_red    = rgb[23:16];
    it.in_green  = rgb[15:8];
    it.in_blue   = rgb[7:0];
    written_pos[{row, col}] = 1'b1;
    pending_items.push_back(it);
    queued++;
  endtask

  task automatic push_query(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
    logic [ADDR_W-1:0] key;
    bwpf_pkg::item_t it;
    key = {src_coord(gen_x, row, col, IMAGE_ROWS), src_coord(gen_y, row, col, IMAGE_COLS)};
    if (!written_pos.exists(key)) begin
      push_write(key[ADDR_W-1:COL_W], key[COL_W-1:0], PIX_W'($urandom));
    end
    it           = '0;
    {it.in_red, it.in_green, it.in_blue} = PIX_W'($urandom);
    it.opcode    = bwpf_pkg::OP_QUERY;
    it.pixel_row = row;
    it.pixel_col = col;
    pending_items.push_back(it);
    queued++;
  endtask

  task automatic load_coefs(input bwpf_pkg::coef_set_t x, input bwpf_pkg::coef_set_t y);
    for (int i = 0; i < NUM_TERMS; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_IDX_W'(bwpf_pkg::REG_X_FROM_ROW + i);
      cfg_data_i <= x[i];
    end
    for (int i = 0; i < NUM_TERMS; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_IDX_W'(bwpf_pkg::REG_Y_FROM_ROW + i);
      cfg_data_i <= y[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_x = x;
    gen_y = y;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || start || pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    longint v;
    case ($urandom_range(7))
      0: v = {$urandom, $urandom};
      1: v = 0;
      2, 3, 4: v = ((longint'($urandom_range(5)) << FRAC_W) | longint'($urandom))
                   - (longint'(3) << FRAC_W);
      5: v = longint'($urandom_range(1 << 27)) - (longint'(1) << 26);
      default: v = ((longint'($urandom_range(1400)) - 700) <<< FRAC_W) + longint'($urandom);
    endcase
    return v[COEF_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(4) == 0) return $urandom_range(1) ? COORD_W'(IMAGE_ROWS - 1) : '0;
    return COORD_W'($urandom_range(IMAGE_ROWS - 1));
  endfunction

  initial begin
    bwpf_pkg::coef_set_t x, y;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    gen_x = bwpf_pkg::COEF_RESET[NUM_TERMS-1:0];
    gen_y = bwpf_pkg::COEF_RESET[NUM_REGS-1:NUM_TERMS];

    // Identity mapping straight after reset: corners and one inner pixel.
    push_write(0, 0, 24'h000000);
    push_write(511, 511, 24'hffffff);
    push_write(0, 511, 24'ha55a0f);
    push_write(511, 0, 24'h0ff05a);
    push_write(255, 256, PIX_W'($urandom));
    push_query(0, 0);
    push_query(511, 511);
    push_query(0, 511);
    push_query(511, 0);
    push_query(255, 256);
    wait_drained();

    // Largest coefficients send every position past the last row and column.
    for (int i = 0; i < NUM_TERMS; i++) begin
      x[i] = 48'h7fff_ffff_ffff;
      y[i] = 48'h7fff_ffff_ffff;
    end
    load_coefs(x, y);
    push_query(0, 0);
    push_query(511, 511);
    push_query(1, 0);
    wait_drained();

    // Most negative coefficients clamp every source coordinate to zero.
    for (int i = 0; i < NUM_TERMS; i++) begin
      x[i] = 48'h8000_0000_0000;
      y[i] = 48'h8000_0000_0000;
    end
    load_coefs(x, y);
    push_query(0, 0);
    push_query(511, 511);
    push_query(0, 1);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      sender_idle_pct = (p < 3) ? 35 : (p < 6) ? 76 : 0;
      if (p == 4) begin
        // Transposed and scaled with negative offsets, so both clamps are hit.
        x = '0;
        y = '0;
        x[1] = 48'h0000_8000_0000;
        x[3] = -(48'd60 << FRAC_W);
        y[0] = 48'h0002_0000_0000;
        y[3] = -(48'd300 << FRAC_W);
      end else begin
        for (int i = 0; i < NUM_TERMS; i++) begin
          x[i] = rand_coef();
          y[i] = rand_coef();
        end
      end
      load_coefs(x, y);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(99) < 45) push_write(rand_coord(), rand_coord(), PIX_W'($urandom));
        else push_query(rand_coord(), rand_coord());
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
